// ----- rtl/mirrored_bit_angle_led_driver_defines.svh -----
// Assertion macros used by the checker file of the LED driver.
// Depends on nothing; include by bare file name.
`ifndef MIRRORED_BIT_ANGLE_LED_DRIVER_DEFINES_SVH
`define MIRRORED_BIT_ANGLE_LED_DRIVER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MBAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mbam check failed");

// next-cycle implication, disabled while reset is low
`define MBAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mbam check failed");

`endif

// ----- rtl/mbam_pkg.sv -----
// Shared types, constants and helpers for the mirrored bit-angle LED driver.
// Depends on nothing.
package mbam_pkg;

    localparam int CHANNELS       = 8;
    localparam int RESOLUTION     = 10;
    localparam int LEVEL_W        = 16;
    localparam int CHAN_FIELD_W   = 3;
    localparam int CFG_W          = 4;
    localparam int SLICE_OUT_W    = 4;
    localparam int CNT_W          = 18;
    localparam int CH_W           = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLICE_W        = $clog2(RESOLUTION);
    localparam int EXP_W          = 5;
    localparam int MIN_LOG2_MAX   = 8;
    localparam int PERIOD_EXP_MAX = 17;
    localparam logic [CFG_W-1:0] MIN_LOG2_RESET = CFG_W'(2);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLIP  = 2'd2
    } t_op;

    typedef struct packed {
        logic                    wr_en;
        logic [CHAN_FIELD_W-1:0] channel;
        logic [LEVEL_W-1:0]      level;
        logic                    flip_en;
        logic                    flip_bank;
        logic                    rd_bank;
        logic [SLICE_W-1:0]      rd_slice;
    } t_frame_cmd;

    // display time of a slice, minus one, in ticks
    function automatic logic [CNT_W-1:0] period_m1(input logic [SLICE_W-1:0] slice,
                                                   input logic [CFG_W-1:0]   min_log2);
        logic [EXP_W-1:0] e;
        logic [CNT_W-1:0] one;
        e   = (min_log2 > CFG_W'(MIN_LOG2_MAX)) ? EXP_W'(MIN_LOG2_MAX) : EXP_W'(min_log2);
        e   = e + EXP_W'(slice);
        if (e > EXP_W'(PERIOD_EXP_MAX)) begin
            e = EXP_W'(PERIOD_EXP_MAX);
        end
        one = CNT_W'(1);
        return (one << e) - one;
    endfunction

    // slice that the pins show, given the next position and direction
    function automatic logic [SLICE_W-1:0] shown_slice(input logic [SLICE_W-1:0] pos,
                                                       input logic               up);
        logic [SLICE_W-1:0] s;
        if (up) begin
            s = (pos == '0) ? '0 : pos - SLICE_W'(1);
        end else begin
            s = (pos >= SLICE_W'(RESOLUTION - 1)) ? SLICE_W'(RESOLUTION - 1)
                                                  : pos + SLICE_W'(1);
        end
        return s;
    endfunction

endpackage

// ----- rtl/mirrored_bit_angle_led_driver.sv -----
// Top level of the mirrored bit-angle modulation LED driver.
// Depends on mbam_pkg and mbam_frame.
//
// Input channel (i_in_valid / o_in_ready) carries one item: op 0 is a timer
// tick, op 1 writes the level of i_channel (top bits of i_level kept), op 2
// transposes all levels into the spare slice bank and queues it. Op 3 only
// reports the current state.
// Output channel (o_out_valid / i_out_ready) returns one result per item:
// latched pin pattern, slice on the pins, sweep direction, pending flip.
// i_cfg_we writes i_cfg_data as log2 of the ticks of the shortest slice;
// write it only while no item is in flight.
// An accepted item lands in the input register, and its result is
// registered in the output register once that register is free.
// One item per clock while the receiver keeps up, since the slice read
// and sweep update are a single register-to-register pass.
// A stalled receiver holds the result; one more item waits in the input
// register, after which o_in_ready drops until the result is taken.
// Reset clears all levels and both banks, selects bank 0, sweeps upward
// from slice 0, and primes the tick counter so the first tick switches.
module mirrored_bit_angle_led_driver import mbam_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_op,
    input  logic [CHAN_FIELD_W-1:0] i_channel,
    input  logic [LEVEL_W-1:0]      i_level,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CHANNELS-1:0]     o_led_pins,
    output logic [SLICE_OUT_W-1:0]  o_active_slice,
    output logic                    o_sweeping_up,
    output logic                    o_flip_pending
);

    logic                    r_in_valid;
    logic [1:0]              r_op;
    logic [CHAN_FIELD_W-1:0] r_channel;
    logic [LEVEL_W-1:0]      r_level;

    logic [CFG_W-1:0]        r_min_log2;
    logic [CNT_W-1:0]        r_cnt,      n_cnt;
    logic [CNT_W-1:0]        r_match_m1, n_match_m1;
    logic [SLICE_W-1:0]      r_pos,      n_pos;
    logic                    r_dir_up,   n_dir_up;
    logic                    r_in_use,   n_in_use;
    logic                    r_queued,   n_queued;
    logic [CHANNELS-1:0]     r_pins,     n_pins;

    logic                    r_out_valid;
    logic [CHANNELS-1:0]     r_out_pins;
    logic [SLICE_OUT_W-1:0]  r_out_slice;
    logic                    r_out_up;
    logic                    r_out_pending;

    logic                    fire;
    logic [SLICE_W-1:0]      shown;
    t_frame_cmd              frame_cmd;
    logic [CHANNELS-1:0]     rd_data;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign shown      = (32'(r_pos) < 32'(RESOLUTION)) ? r_pos : '0;

    mbam_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (frame_cmd),
        .o_rd_data (rd_data)
    );

    always_comb begin
        frame_cmd.wr_en     = 1'b0;
        frame_cmd.channel   = r_channel;
        frame_cmd.level     = r_level;
        frame_cmd.flip_en   = 1'b0;
        frame_cmd.flip_bank = ~r_in_use;
        frame_cmd.rd_bank   = r_in_use;
        frame_cmd.rd_slice  = shown;

        if (fire) begin
            case (t_op'(r_op))
                OP_WRITE: begin
                    frame_cmd.wr_en = 1'b1;
                end
                OP_FLIP: begin
                    frame_cmd.flip_en = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_match_m1 = r_match_m1;
        n_pos      = r_pos;
        n_dir_up   = r_dir_up;
        n_in_use   = r_in_use;
        n_queued   = r_queued;
        n_pins     = r_pins;

        if (fire) begin
            case (t_op'(r_op))
                OP_TICK: begin
                    if (r_cnt < r_match_m1) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_pins     = rd_data;
                        n_match_m1 = period_m1(shown, r_min_log2);
                        n_cnt      = '0;
                        if (r_dir_up) begin
                            if (shown == SLICE_W'(RESOLUTION - 1)) begin
                                n_in_use = r_queued;
                                n_pos    = SLICE_W'(RESOLUTION - 1);
                                n_dir_up = 1'b0;
                            end else begin
                                n_pos = shown + SLICE_W'(1);
                            end
                        end else begin
                            if (shown == '0) begin
                                n_in_use = r_queued;
                                n_pos    = '0;
                                n_dir_up = 1'b1;
                            end else begin
                                n_pos = shown - SLICE_W'(1);
                            end
                        end
                    end
                end
                OP_FLIP: begin
                    n_queued = ~r_in_use;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_min_log2  <= MIN_LOG2_RESET;
            r_cnt       <= '1;
            r_match_m1  <= period_m1('0, MIN_LOG2_RESET);
            r_pos       <= '0;
            r_dir_up    <= 1'b1;
            r_in_use    <= 1'b0;
            r_queued    <= 1'b0;
            r_pins      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_log2 <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_cnt      <= n_cnt;
            r_match_m1 <= n_match_m1;
            r_pos      <= n_pos;
            r_dir_up   <= n_dir_up;
            r_in_use   <= n_in_use;
            r_queued   <= n_queued;
            r_pins     <= n_pins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op      <= i_op;
            r_channel <= i_channel;
            r_level   <= i_level;
        end
        if (fire) begin
            r_out_pins    <= n_pins;
            r_out_slice   <= SLICE_OUT_W'(shown_slice(n_pos, n_dir_up));
            r_out_up      <= n_dir_up;
            r_out_pending <= n_queued != n_in_use;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_led_pins     = r_out_pins;
    assign o_active_slice = r_out_slice;
    assign o_sweeping_up  = r_out_up;
    assign o_flip_pending = r_out_pending;

endmodule

// ----- rtl/mbam_frame.sv -----
// Channel level store and the two transposed slice banks.
// Depends on mbam_pkg.
module mbam_frame import mbam_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_frame_cmd          i_cmd,
    output logic [CHANNELS-1:0] o_rd_data
);

    logic [RESOLUTION-1:0] r_levels [CHANNELS];
    logic [CHANNELS-1:0]   r_slices [2][RESOLUTION];
    logic [CHANNELS-1:0]   n_transposed [RESOLUTION];
    logic                  wr_hit;

    assign wr_hit = i_cmd.wr_en && (32'(i_cmd.channel) < 32'(CHANNELS));

    always_comb begin
        for (int b = 0; b < RESOLUTION; b++) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                n_transposed[b][ch] = r_levels[ch][b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_levels[ch] <= '0;
            end
            for (int k = 0; k < 2; k++) begin
                for (int b = 0; b < RESOLUTION; b++) begin
                    r_slices[k][b] <= '0;
                end
            end
        end else begin
            if (wr_hit) begin
                r_levels[i_cmd.channel[CH_W-1:0]] <=
                    i_cmd.level[LEVEL_W-1 -: RESOLUTION];
            end
            if (i_cmd.flip_en) begin
                for (int b = 0; b < RESOLUTION; b++) begin
                    r_slices[i_cmd.flip_bank][b] <= n_transposed[b];
                end
            end
        end
    end

    assign o_rd_data = r_slices[i_cmd.rd_bank][i_cmd.rd_slice];

endmodule

// ----- rtl/mbam_checker.sv -----
// Port-level checks of the LED driver, bound to the top level.
// Depends on mbam_pkg and mirrored_bit_angle_led_driver_defines.svh.
`include "mirrored_bit_angle_led_driver_defines.svh"

module mbam_checker import mbam_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [CHANNELS-1:0]     o_led_pins,
    input logic [SLICE_OUT_W-1:0]  o_active_slice,
    input logic                    o_sweeping_up,
    input logic                    o_flip_pending
);

    `MBAM_ASSERT_IMP(a_slice_range, i_clk, i_rst_n, o_out_valid, o_active_slice <= SLICE_OUT_W'(RESOLUTION - 1))

    `MBAM_ASSERT_IMP(a_backpressure_cause, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    `MBAM_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_led_pins) && $stable(o_active_slice) && $stable(o_sweeping_up) && $stable(o_flip_pending))

    `MBAM_ASSERT_NXT(a_result_follows_item, i_clk, i_rst_n, i_in_valid && o_in_ready && !o_out_valid, ##1 o_out_valid)

endmodule

bind mirrored_bit_angle_led_driver mbam_checker u_mbam_checker (.*);
